[rtl/core/i2p_pkg.sv]
// Shared types, codes and character helpers for the infix-to-postfix converter.
package i2p_pkg;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_TIMES  = 8'h2A;
  localparam logic [7:0] CH_POWER  = 8'h5E;

  localparam logic [1:0] OP_LPAREN = 2'd0;
  localparam logic [1:0] OP_PLUS   = 2'd1;
  localparam logic [1:0] OP_TIMES  = 2'd2;
  localparam logic [1:0] OP_POWER  = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_CLOSE    = 2'd2;
  localparam logic [1:0] ERR_OPEN     = 2'd3;

  typedef enum logic [2:0] {
    CLS_IGNORE,
    CLS_OPERAND,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OPERATOR
  } cls_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       fin;
    cls_t       cls;
    logic [1:0] code;
  } item_t;

  function automatic logic [7:0] op_char(input logic [1:0] code);
    logic [7:0] ch;
    unique case (code)
      OP_LPAREN: ch = CH_LPAREN;
      OP_PLUS:   ch = CH_PLUS;
      OP_TIMES:  ch = CH_TIMES;
      default:   ch = CH_POWER;
    endcase
    return ch;
  endfunction

  function automatic item_t classify(input logic [7:0] sym, input logic fin);
    item_t it;
    it.sym  = sym;
    it.fin  = fin;
    it.cls  = CLS_IGNORE;
    it.code = OP_LPAREN;
    if ((sym >= 8'h30 && sym <= 8'h39) || (sym >= 8'h41 && sym <= 8'h5A) ||
        (sym >= 8'h61 && sym <= 8'h7A)) begin
      it.cls = CLS_OPERAND;
    end else if (sym == CH_LPAREN) begin
      it.cls = CLS_LPAREN;
    end else if (sym == CH_RPAREN) begin
      it.cls = CLS_RPAREN;
    end else if (sym == CH_PLUS) begin
      it.cls  = CLS_OPERATOR;
      it.code = OP_PLUS;
    end else if (sym == CH_TIMES) begin
      it.cls  = CLS_OPERATOR;
      it.code = OP_TIMES;
    end else if (sym == CH_POWER) begin
      it.cls  = CLS_OPERATOR;
      it.code = OP_POWER;
    end
    return it;
  endfunction

endpackage

[rtl/core/i2p_if.sv]
// Valid/ready channel interfaces for the converter's input and result words.
interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_in;
  logic       final_char;

  modport source(output valid, symbol_in, final_char, input ready);
  modport sink(input valid, symbol_in, final_char, output ready);
endinterface

interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_out;
  logic       has_symbol;
  logic       end_of_run;
  logic       end_of_expression;
  logic [1:0] error_code;

  modport source(output valid, symbol_out, has_symbol, end_of_run, end_of_expression,
                 error_code, input ready);
  modport sink(input valid, symbol_out, has_symbol, end_of_run, end_of_expression,
               error_code, output ready);
endinterface

[rtl/core/infix_to_postfix_converter_top.sv]
// Top level of the shunting-yard infix-to-postfix converter.
// The converter takes one ASCII character per input word and returns postfix
// characters, at most one per result word; the last word of each input that
// yields words carries end_of_run, and the last word of a final character
// carries end_of_expression and the error code. A two-entry queue lets input
// words arrive while the back end works. The back end passes an operand on,
// pushes '(' and skips ignored characters; '+', '*', '^' and ')' first pop the
// operators they displace, and an error-free final character then flushes the
// stack. The sequencer pops one stack entry per cycle unless output
// back-pressure holds it, from a stack memory of STACK_DEPTH entries with one
// read and one write port.
module infix_to_postfix_converter_top import i2p_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  i2p_in_if.sink    in_if,
  i2p_out_if.source out_if
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  i2p_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

[rtl/core/i2p_front.sv]
// Front end: accepts input words, classifies them and queues them for the back end.
module i2p_front import i2p_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  i2p_in_if.sink   in_if,
  output logic     q_valid,
  output item_t    q_item,
  input  logic     q_pop
);

  item_t       slot_r [2];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  logic        pop;

  assign in_if.ready = (cnt_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign pop         = q_pop && q_valid;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= classify(in_if.symbol_in, in_if.final_char);
    end
  end

endmodule

[rtl/core/i2p_back.sv]
// Back end: operator stack, pop sequencer, end-of-run marking and result register.
module i2p_back import i2p_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  item_t     q_item,
  output logic      q_pop,
  i2p_out_if.source out_if
);

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OP    = 3'd1;
  localparam logic [2:0] S_CLOSE = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;

  logic [1:0]       stack_mem [STACK_DEPTH];
  logic [1:0]       rd_r;
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_nxt_m1;
  logic [1:0]       err_r, err_nxt;
  logic             byp_v_r, byp_v_nxt;
  logic [1:0]       byp_r, byp_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [7:0]       pend_sym_r, pend_sym_nxt;
  logic             out_v_r, out_v_nxt;
  logic [7:0]       sym_out_r;
  logic             has_r, eor_r, eoe_r;
  logic [1:0]       errc_r;
  logic             we;
  logic [1:0]       wdata;
  logic [IDX_W-1:0] rd_addr;
  logic [1:0]       top;
  logic             out_free;
  logic             ok_emit;
  logic             emit;
  logic [7:0]       emit_sym;
  logic             fin_out;
  logic             done;
  logic             full;
  logic             pop_ok;
  logic             out_load;

  assign top      = byp_v_r ? byp_r : rd_r;
  assign out_free = !out_v_r || out_if.ready;
  assign ok_emit  = !pend_v_r || out_free;
  assign full     = (cnt_r >= CNT_W'(STACK_DEPTH));
  assign pop_ok   = (cnt_r != '0) && (top != OP_LPAREN) &&
                    ((top > q_item.code) || ((top == q_item.code) && (q_item.code != OP_POWER)));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    byp_nxt   = byp_r;
    byp_v_nxt = byp_v_r;
    we        = 1'b0;
    wdata     = q_item.code;
    emit      = 1'b0;
    emit_sym  = op_char(top);
    fin_out   = 1'b0;
    q_pop     = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (err_r != ERR_NONE) begin
            state_nxt = S_END;
          end else begin
            unique case (q_item.cls)
              CLS_OPERAND: begin
                if (ok_emit) begin
                  emit     = 1'b1;
                  emit_sym = q_item.sym;
                  done     = 1'b1;
                end
              end
              CLS_LPAREN: begin
                if (full) begin
                  err_nxt = ERR_OVERFLOW;
                  cnt_nxt = '0;
                end else begin
                  we        = 1'b1;
                  wdata     = OP_LPAREN;
                  cnt_nxt   = cnt_r + CNT_W'(1);
                  byp_v_nxt = 1'b1;
                  byp_nxt   = OP_LPAREN;
                end
                done = 1'b1;
              end
              CLS_RPAREN:   state_nxt = S_CLOSE;
              CLS_OPERATOR: state_nxt = S_OP;
              default:      done = 1'b1;
            endcase
          end
        end
      end
      S_OP: begin
        if (pop_ok) begin
          if (ok_emit) begin
            emit    = 1'b1;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end else begin
          if (full) begin
            if (err_r == ERR_NONE) err_nxt = ERR_OVERFLOW;
            cnt_nxt = '0;
          end else begin
            we        = 1'b1;
            cnt_nxt   = cnt_r + CNT_W'(1);
            byp_v_nxt = 1'b1;
            byp_nxt   = q_item.code;
          end
          done = 1'b1;
        end
      end
      S_CLOSE: begin
        if (cnt_r == '0) begin
          if (err_r == ERR_NONE) err_nxt = ERR_CLOSE;
          done = 1'b1;
        end else if (top == OP_LPAREN) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          done    = 1'b1;
        end else if (ok_emit) begin
          emit    = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_FLUSH: begin
        if (cnt_r == '0) begin
          state_nxt = S_END;
        end else if (top == OP_LPAREN) begin
          if (err_r == ERR_NONE) err_nxt = ERR_OPEN;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else if (ok_emit) begin
          emit    = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_END: begin
        if (!pend_v_r && !q_item.fin) begin
          q_pop     = 1'b1;
          state_nxt = S_IDLE;
        end else if (out_free) begin
          fin_out   = 1'b1;
          q_pop     = 1'b1;
          state_nxt = S_IDLE;
          if (q_item.fin) begin
            cnt_nxt = '0;
            err_nxt = ERR_NONE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (done) begin
      state_nxt = (q_item.fin && (err_nxt == ERR_NONE)) ? S_FLUSH : S_END;
    end
    if (cnt_nxt < cnt_r) begin
      byp_v_nxt = 1'b0;
    end
  end

  assign cnt_nxt_m1 = cnt_nxt - CNT_W'(1);
  assign rd_addr    = cnt_nxt_m1[IDX_W-1:0];

  assign out_load     = (emit && pend_v_r) || fin_out;
  assign pend_v_nxt   = emit || (pend_v_r && !q_pop);
  assign pend_sym_nxt = emit ? emit_sym : pend_sym_r;
  assign out_v_nxt    = out_load || (out_v_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      err_r    <= ERR_NONE;
      byp_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      err_r    <= err_nxt;
      byp_v_r  <= byp_v_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_r      <= byp_nxt;
    pend_sym_r <= pend_sym_nxt;
    if (out_load) begin
      if (fin_out) begin
        sym_out_r <= pend_v_r ? pend_sym_r : 8'h00;
        has_r     <= pend_v_r;
        eor_r     <= 1'b1;
        eoe_r     <= q_item.fin;
        errc_r    <= q_item.fin ? err_r : ERR_NONE;
      end else begin
        sym_out_r <= pend_sym_r;
        has_r     <= 1'b1;
        eor_r     <= 1'b0;
        eoe_r     <= 1'b0;
        errc_r    <= ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[cnt_r[IDX_W-1:0]] <= wdata;
    end
    rd_r <= stack_mem[rd_addr];
  end

  assign out_if.valid             = out_v_r;
  assign out_if.symbol_out        = sym_out_r;
  assign out_if.has_symbol        = has_r;
  assign out_if.end_of_run        = eor_r;
  assign out_if.end_of_expression = eoe_r;
  assign out_if.error_code        = errc_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("operator stack count beyond depth");

  a_err_on_eoe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (errc_r != ERR_NONE)) |-> eoe_r)
    else $error("error code on a word that does not close the expression");

  a_eoe_eor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && eoe_r) |-> eor_r)
    else $error("end of expression without end of run");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("pending symbol left over between items");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_END && q_pop && q_item.fin) |=> (cnt_r == '0 && err_r == ERR_NONE))
    else $error("stack or error not cleared after the final character");
`endif

endmodule
